// ----- hw/rtl/dovn_pkg.sv -----
// Shared constants, control word layout and month table for the date normalizer.
package dovn_pkg;

    // Day counter width; day_in is cut to its low DAY_BITS bits when narrower than 16.
    localparam int DAY_BITS = 16;
    localparam int DAY_W    = (DAY_BITS < 16) ? DAY_BITS : 16;

    localparam int MONTHS_PER_YEAR = 12;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [4:0]  LEAP_FEB_LEN = 5'd29;
    localparam logic [15:0] DEFAULT_YEAR = 16'd1970;

    // Reciprocals for constant division: x / 12 for x < 2^15, y / 100 for y < 43690.
    // Years reaching the divide stay below 36000.
    localparam logic [15:0] RECIP12  = 16'd43691;
    localparam int          SH12     = 19;
    localparam logic [15:0] RECIP100 = 16'd41944;
    localparam int          SH100    = 22;

    // Microprogram
    localparam int STEPS  = 8;
    localparam int STEP_W = $clog2(STEPS);

    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CHECK  = 4'd2;
    localparam logic [3:0] OP_MUL12  = 4'd3;
    localparam logic [3:0] OP_MDIV   = 4'd4;
    localparam logic [3:0] OP_MUL100 = 4'd5;
    localparam logic [3:0] OP_YDIV   = 4'd6;
    localparam logic [3:0] OP_FOLD   = 4'd7;
    localparam logic [3:0] OP_EMIT   = 4'd8;

    localparam logic [2:0] C_NEVER   = 3'd0;
    localparam logic [2:0] C_NOACC   = 3'd1;
    localparam logic [2:0] C_INVALID = 3'd2;
    localparam logic [2:0] C_NOFIT   = 3'd3;
    localparam logic [2:0] C_OBUSY   = 3'd4;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic acc;
        logic invalid;
        logic nofit;
        logic obusy;
    } t_stat;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:                    len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- hw/rtl/dovn_ucode.sv -----
// Microcode ROM and step counter with conditional jumps.
module dovn_ucode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dovn_pkg::t_stat i_stat,
    output dovn_pkg::t_ctrl o_ctrl
);
    import dovn_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             ctrl;
    logic              take;

    always_comb begin
        unique case (r_step)
            3'd0:    ctrl = '{op: OP_LOAD,   cond: C_NOACC,   target: 3'd0};
            3'd1:    ctrl = '{op: OP_CHECK,  cond: C_INVALID, target: 3'd7};
            3'd2:    ctrl = '{op: OP_MUL12,  cond: C_NEVER,   target: 3'd0};
            3'd3:    ctrl = '{op: OP_MDIV,   cond: C_NEVER,   target: 3'd0};
            3'd4:    ctrl = '{op: OP_MUL100, cond: C_NEVER,   target: 3'd0};
            3'd5:    ctrl = '{op: OP_YDIV,   cond: C_NEVER,   target: 3'd0};
            3'd6:    ctrl = '{op: OP_FOLD,   cond: C_NOFIT,   target: 3'd6};
            // last step: falling through wraps the counter back to the load step
            3'd7:    ctrl = '{op: OP_EMIT,   cond: C_OBUSY,   target: 3'd7};
            default: ctrl = '{op: OP_NOP,    cond: C_NEVER,   target: 3'd0};
        endcase
    end

    always_comb begin
        unique case (ctrl.cond)
            C_NOACC:   take = !i_stat.acc;
            C_INVALID: take = i_stat.invalid;
            C_NOFIT:   take = i_stat.nofit;
            C_OBUSY:   take = i_stat.obusy;
            default:   take = 1'b0;
        endcase
        n_step = take ? ctrl.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ----- hw/rtl/dovn_datapath.sv -----
// Date datapath: operand registers, shared constant multiplier, month folding, output stage.
module dovn_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dovn_pkg::t_ctrl             i_ctrl,
    input  logic                        i_acc,
    input  logic signed [15:0]          i_day_in,
    input  logic signed [15:0]          i_month_in,
    input  logic signed [15:0]          i_year_in,
    input  logic                        i_out_stall,
    output dovn_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    output logic [4:0]                  o_day,
    output logic [3:0]                  o_month,
    output logic [15:0]                 o_year,
    output logic                        o_inval
);
    import dovn_pkg::*;

    logic [DAY_W-1:0] r_day;
    logic [3:0]       r_month;
    logic [15:0]      r_year;
    logic [14:0]      r_mx;
    logic [31:0]      r_prod;
    logic [6:0]       r_r100;
    logic [1:0]       r_q2;
    logic             r_inval;
    logic             r_ovalid;
    logic [4:0]       r_oday;
    logic [3:0]       r_omonth;
    logic [15:0]      r_oyear;
    logic             r_oinval;

    logic [DAY_W-1:0] d_in;
    logic             in_ok;
    logic [15:0]      mul_a;
    logic [15:0]      mul_k;
    logic [11:0]      q12;
    logic [14:0]      q12x;
    logic [14:0]      mrem;
    logic [9:0]       q100;
    logic [15:0]      q100x;
    logic [15:0]      yrem;
    logic             leap;
    logic [4:0]       len;
    logic [DAY_W-1:0] len_ext;
    logic             nofit;
    logic             out_free;

    assign d_in  = i_day_in[DAY_W-1:0];
    assign in_ok = !d_in[DAY_W-1] && (d_in != '0) &&
                   !i_month_in[15] && (i_month_in != '0) &&
                   !i_year_in[15]  && (i_year_in != '0);

    always_comb begin
        if (i_ctrl.op == OP_MUL100) begin
            mul_a = r_year;
            mul_k = RECIP100;
        end else begin
            mul_a = {1'b0, r_mx};
            mul_k = RECIP12;
        end
    end

    assign q12   = r_prod[SH12 +: 12];
    assign q12x  = 15'(q12) * 15'(MONTHS_PER_YEAR);
    assign mrem  = r_mx - q12x;
    assign q100  = r_prod[SH100 +: 10];
    assign q100x = 16'(q100) * 16'd100;
    assign yrem  = r_year - q100x;

    // Gregorian leap: divisible by 4, not by 100 unless by 400
    assign leap    = (r_year[1:0] == 2'b00) && ((r_r100 != '0) || (r_q2 == 2'b00));
    assign len     = ((r_month == MONTH_FEB) && leap) ? LEAP_FEB_LEN : month_len(r_month);
    assign len_ext = DAY_W'(len);
    assign nofit   = r_day > len_ext;

    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_acc) begin
                    r_day   <= d_in;
                    r_mx    <= i_month_in[14:0] - 15'd1;
                    r_year  <= i_year_in;
                    r_inval <= !in_ok;
                end
            end
            OP_CHECK: begin
                if (r_inval) begin
                    r_day   <= DAY_W'(1);
                    r_month <= MONTH_JAN;
                    r_year  <= DEFAULT_YEAR;
                end
            end
            OP_MUL12, OP_MUL100: begin
                r_prod <= mul_a * mul_k;
            end
            OP_MDIV: begin
                r_month <= mrem[3:0] + 4'd1;
                r_year  <= r_year + 16'(q12);
            end
            OP_YDIV: begin
                r_r100 <= yrem[6:0];
                r_q2   <= q100[1:0];
            end
            OP_FOLD: begin
                if (nofit) begin
                    r_day <= r_day - len_ext;
                    if (r_month == MONTH_DEC) begin
                        r_month <= MONTH_JAN;
                        r_year  <= r_year + 16'd1;
                        if (r_r100 == 7'd99) begin
                            r_r100 <= '0;
                            r_q2   <= r_q2 + 2'd1;
                        end else begin
                            r_r100 <= r_r100 + 7'd1;
                        end
                    end else begin
                        r_month <= r_month + 4'd1;
                    end
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    r_oday   <= r_day[4:0];
                    r_omonth <= r_month;
                    r_oyear  <= r_year;
                    r_oinval <= r_inval;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= (i_ctrl.op == OP_EMIT);
        end
    end

    assign o_stat.acc     = i_acc;
    assign o_stat.invalid = r_inval;
    assign o_stat.nofit   = nofit;
    assign o_stat.obusy   = !out_free;

    assign o_out_valid = r_ovalid;
    assign o_day       = r_oday;
    assign o_month     = r_omonth;
    assign o_year      = r_oyear;
    assign o_inval     = r_oinval;

endmodule

// ----- hw/rtl/date_overflow_normalizer.sv -----
// Top level of the date normalizer: microcode sequencer plus date datapath.
//
// Takes a signed day, month and year and returns one normalized Gregorian date per input
// beat. If any input is zero or negative the result is 1/1/1970 with o_was_invalid set.
// Otherwise the month is reduced into 1..12 with its overflow carried into the year, and
// excess days are folded forward one month per cycle (February has 29 days in leap years).
// The fold step repeats once per folded month. The month and year divisions by 12 and 100
// go through one shared 16x16 constant multiplier in four steps. An invalid item skips
// straight to the output step. A finished result sits in the output register, and the
// next input beat is accepted while it waits to be taken.
module date_overflow_normalizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_day_in,
    input  logic signed [15:0] i_month_in,
    input  logic signed [15:0] i_year_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_day_out,
    output logic [3:0]         o_month_out,
    output logic [15:0]        o_year_out,
    output logic               o_was_invalid
);
    import dovn_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  acc;

    // Take a beat only on the load step of the microprogram
    assign o_stall = (ctrl.op != OP_LOAD);
    assign acc     = i_valid && !o_stall;

    dovn_ucode u_ucode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    dovn_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_acc       (acc),
        .i_day_in    (i_day_in),
        .i_month_in  (i_month_in),
        .i_year_in   (i_year_in),
        .i_out_stall (i_stall),
        .o_stat      (stat),
        .o_out_valid (o_valid),
        .o_day       (o_day_out),
        .o_month     (o_month_out),
        .o_year      (o_year_out),
        .o_inval     (o_was_invalid)
    );

endmodule
